// ----- hw/rtl/mpq_pkg.sv -----
// Shared types and constants for the max-priority ticket queue.
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 1024;
    localparam int LIMIT_W             = 11;
    localparam int VALUE_W             = 32;
    localparam int TICKET_W            = 32;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(1024);
    localparam logic [TICKET_W-1:0] TICKET_FIRST = TICKET_W'(1);
    localparam logic [TICKET_W-1:0] TICKET_NONE  = '0;
    localparam logic [TICKET_W-1:0] TICKET_LAST  = '1;

    // Request kinds.
    typedef enum logic
    {
        REQ_INSERT  = 1'b0,
        REQ_EXTRACT = 1'b1
    } req_kind_t;

    // Input request payload.
    typedef struct packed
    {
        req_kind_t                 req_type;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Result payload.
    typedef struct packed
    {
        logic [TICKET_W-1:0] ticket;
        logic                found;
    } rsp_t;

    // One stored entry of the sorted chain.
    typedef struct packed
    {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [TICKET_W-1:0]       ticket;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed
    {
        logic                      ins;
        logic                      ext;
        logic signed [VALUE_W-1:0] value;
        logic [TICKET_W-1:0]       ticket;
    } chain_cmd_t;

endpackage

// ----- hw/rtl/max_priority_ticket_queue.sv -----
// Top level of the max-priority ticket queue built on a sorted cell chain.
// An extract request's result is written to the output register when the request is accepted.
// Throughput: one request per cycle; every cell updates in parallel from its neighbors.
// An insert request gives no result and is done in the cycle it is accepted.
// A request waits only while a result sits in the output register and is not taken.
// Reset (rst_n low, asynchronous) empties the chain, sets the limit to 1024 and ticket to 1.
`timescale 1ns / 1ps

module max_priority_ticket_queue
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

    logic [LIMIT_W-1:0]  limit_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [TICKET_W-1:0] ticket_reg;
    logic [TICKET_W-1:0] ticket_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic       accept;
    logic       room;
    logic       head_found;
    chain_cmd_t cmd;

    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_keep  [QUEUE_DEPTH];

    assign cfg_ready = 1'b1;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Room check against the smaller of the limit and the chain length.
    assign room = (CMP_W'(occ_reg) < CMP_W'(limit_reg))
               && (CMP_W'(occ_reg) < CMP_W'(QUEUE_DEPTH));

    // The head of the chain holds the largest value, oldest first.
    assign head_found = cell_entry[0].valid && (cell_entry[0].value > 0);

    // Command broadcast to the chain.
    assign cmd.ins    = accept && (req.req_type == REQ_INSERT) && room;
    assign cmd.ext    = accept && (req.req_type == REQ_EXTRACT) && head_found;
    assign cmd.value  = req.value;
    assign cmd.ticket = ticket_reg;

    // Sorted chain of cells.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_k;
            entry_t right_e;

            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_inner_l
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner_r
                assign right_e = cell_entry[gi+1];
            end

            mpq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .keep        (cell_keep[gi])
            );
        end
    endgenerate

    // Counters and result register next values.
    always_comb
    begin
        occ_next       = occ_reg;
        ticket_next    = ticket_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            unique case (req.req_type)
                REQ_INSERT:
                begin
                    if (room)
                    begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    ticket_next = (ticket_reg == TICKET_LAST) ? TICKET_FIRST
                                                              : ticket_reg + TICKET_W'(1);
                end
                REQ_EXTRACT:
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.found  = head_found;
                    rsp_next.ticket = head_found ? cell_entry[0].ticket : TICKET_NONE;
                    if (head_found)
                    begin
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            occ_reg       <= '0;
            ticket_reg    <= TICKET_FIRST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            occ_reg       <= occ_next;
            ticket_reg    <= ticket_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    // The entry count never exceeds the chain length.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(QUEUE_DEPTH))
        else $error("occupancy above chain length");

    // A successful extract removes exactly one entry.
    a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ext |=> (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("extract did not lower occupancy by one");

    // A result without a hit carries ticket zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.found) |-> (rsp_reg.ticket == TICKET_NONE))
        else $error("miss result with nonzero ticket");

    // The ticket counter never yields zero.
    a_ticket_nz: assert property (@(posedge clk) disable iff (!rst_n)
        ticket_reg != TICKET_NONE)
        else $error("ticket counter reached zero");

    // A nonempty queue always has a valid entry in the head cell.
    a_head_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != '0) |-> cell_entry[0].valid)
        else $error("nonempty queue with empty head cell");
`endif

endmodule

// ----- hw/rtl/mpq_cell.sv -----
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module mpq_cell
    import mpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_cmd_t cmd,
    input  entry_t     left_entry,
    input  logic       left_keep,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       keep
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [TICKET_W-1:0]       ticket_reg;
    logic [TICKET_W-1:0]       ticket_next;

    // The entry stays ahead of a new one when its value is at least as large,
    // since the new entry is always the youngest.
    assign keep = valid_reg && (value_reg >= cmd.value);

    assign entry.valid  = valid_reg;
    assign entry.value  = value_reg;
    assign entry.ticket = ticket_reg;

    // Select the next content: stay, take the new entry, or shift.
    always_comb
    begin
        valid_next  = valid_reg;
        value_next  = value_reg;
        ticket_next = ticket_reg;
        if (cmd.ext)
        begin
            valid_next  = right_entry.valid;
            value_next  = right_entry.value;
            ticket_next = right_entry.ticket;
        end
        else if (cmd.ins && !keep)
        begin
            if (left_keep)
            begin
                valid_next  = 1'b1;
                value_next  = cmd.value;
                ticket_next = cmd.ticket;
            end
            else
            begin
                valid_next  = left_entry.valid;
                value_next  = left_entry.value;
                ticket_next = left_entry.ticket;
            end
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        ticket_reg <= ticket_next;
    end

endmodule

// ----- sim/max_priority_ticket_queue_tb.sv -----
// Self-checking testbench for the max-priority ticket queue: directed cases, then random traffic.
`timescale 1ns / 1ps

module max_priority_ticket_queue_tb;
    import mpq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int IDLE_PCT    = 23;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;

    bit idle_on        = 1'b1;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    // Shadow copy of the queue contents, in arrival order.
    logic signed [VALUE_W-1:0] held_value[$];
    logic [TICKET_W-1:0]       held_ticket[$];
    logic [TICKET_W-1:0]       ticket_next = TICKET_FIRST;
    logic [LIMIT_W-1:0]        limit_model = LIMIT_RESET;

    // Results still owed by the block, oldest first.
    rsp_t pending_results[$];

    max_priority_ticket_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the shadow queue for one accepted request and record any result it owes.
    function automatic void apply_request(input req_t item);
        int                        cap;
        int                        pos;
        bit                        hit;
        logic signed [VALUE_W-1:0] best;
        rsp_t                      outcome;
        cap = (int'(limit_model) < DEPTH) ? int'(limit_model) : DEPTH;
        if (item.req_type == REQ_INSERT)
        begin
            if (held_value.size() < cap)
            begin
                held_value.push_back(item.value);
                held_ticket.push_back(ticket_next);
            end
            // The ticket is used up even when the entry is dropped.
            ticket_next = (ticket_next == TICKET_LAST) ? TICKET_FIRST : ticket_next + 1'b1;
        end
        else
        begin
            best = '0;
            hit  = 1'b0;
            pos  = 0;
            // Strictly greater keeps the oldest among equal values.
            for (int i = 0; i < held_value.size(); i++)
            begin
                if (held_value[i] > best)
                begin
                    best = held_value[i];
                    pos  = i;
                    hit  = 1'b1;
                end
            end
            if (hit)
            begin
                outcome.ticket = held_ticket[pos];
                outcome.found  = 1'b1;
                held_value.delete(pos);
                held_ticket.delete(pos);
            end
            else
            begin
                outcome.ticket = TICKET_NONE;
                outcome.found  = 1'b0;
            end
            pending_results.push_back(outcome);
        end
    endfunction

    // Pick an insert value; neg_pct sets how often it is zero or negative.
    function automatic logic signed [VALUE_W-1:0] pick_value(input int neg_pct);
        int                        roll;
        logic signed [VALUE_W-1:0] v;
        roll = $urandom_range(99);
        if (roll < neg_pct)
        begin
            case ($urandom_range(2))
                0:       v = '0;
                1:       v = {1'b1, 31'($urandom())};
                default: v = {1'b1, 31'h0};
            endcase
        end
        else if (roll < neg_pct + 55)
        begin
            // A narrow range gives many equal values.
            v = VALUE_W'($urandom_range(16, 1));
        end
        else if (roll < neg_pct + 65)
        begin
            v = {1'b0, 31'h7FFF_FFFF};
        end
        else
        begin
            v = $urandom();
            if (neg_pct == 0)
            begin
                v[VALUE_W-1] = 1'b0;
            end
        end
        return v;
    endfunction

    // Present one request and hold it until the block accepts it.
    task automatic send_request(input req_kind_t kind, input logic signed [VALUE_W-1:0] val);
        req_t item;
        item.req_type = kind;
        item.value    = val;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        apply_request(item);
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic wait_for_results(input int settle);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // Write the capacity limit once the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        wait_for_results(SETTLE);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid   <= 1'b0;
        limit_model  = lim;
    endtask

    // Random mix of inserts and extracts.
    task automatic run_traffic(input int count, input int ext_pct, input int neg_pct,
                               input bit pause_midway);
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
            begin
                wait_for_results(0);
            end
            if ($urandom_range(99) < ext_pct)
            begin
                send_request(REQ_EXTRACT, $urandom());
            end
            else
            begin
                send_request(REQ_INSERT, pick_value(neg_pct));
            end
        end
    endtask

    // Empty queue, values that never qualify, extreme values and ties.
    task automatic test_empty_and_ties();
        send_request(REQ_EXTRACT, $urandom());
        send_request(REQ_INSERT, '0);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_INSERT, {1'b1, 31'h0});
        send_request(REQ_EXTRACT, $urandom());
        send_request(REQ_INSERT, {1'b0, 31'h7FFF_FFFF});
        send_request(REQ_INSERT, 32'sd1);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_INSERT, 32'sd5);
        repeat (5) send_request(REQ_EXTRACT, $urandom());
    endtask

    // A zero limit drops every insert; a limit above the depth is capped.
    task automatic test_zero_and_wide_limit();
        write_limit('0);
        send_request(REQ_INSERT, 32'sd9);
        send_request(REQ_INSERT, {1'b0, 31'h7FFF_FFFF});
        send_request(REQ_EXTRACT, $urandom());
        write_limit('1);
        send_request(REQ_INSERT, 32'sd7);
        send_request(REQ_EXTRACT, $urandom());
    endtask

    // A limit lowered below the occupancy keeps held entries and drops new ones.
    task automatic test_shrunk_limit();
        write_limit(LIMIT_RESET);
        send_request(REQ_INSERT, 32'sd3);
        send_request(REQ_INSERT, 32'sd2);
        send_request(REQ_INSERT, 32'sd1);
        write_limit(LIMIT_W'(held_value.size() - 1));
        send_request(REQ_INSERT, 32'sd8);
        repeat (2) send_request(REQ_EXTRACT, $urandom());
        send_request(REQ_INSERT, 32'sd6);
        repeat (2) send_request(REQ_EXTRACT, $urandom());
    endtask

    // A small limit just above the stuck entries, so the queue fills often.
    task automatic test_small_limit_traffic();
        write_limit(LIMIT_W'(held_value.size() + 5));
        run_traffic(250, 45, 0, 1'b0);
    endtask

    // Full rate on both sides with no idling at all.
    task automatic test_steady_traffic();
        write_limit(LIMIT_RESET);
        idle_on = 1'b0;
        run_traffic(300, 50, 10, 1'b0);
        idle_on = 1'b1;
    endtask

    // A random limit, with the sender pausing halfway until all results are in.
    task automatic test_random_limit_traffic();
        write_limit(LIMIT_W'($urandom_range(2047, held_value.size() + 1)));
        run_traffic(250, 50, 10, 1'b1);
    endtask

    // Fill the queue to its depth, then insert past it.
    task automatic test_fill_to_depth();
        write_limit('1);
        while (held_value.size() < DEPTH)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_request(REQ_EXTRACT, $urandom());
            end
            else
            begin
                send_request(REQ_INSERT, pick_value(0));
            end
        end
        repeat (4) send_request(REQ_INSERT, pick_value(0));
        send_request(REQ_EXTRACT, $urandom());
        repeat (2) send_request(REQ_INSERT, pick_value(0));
        repeat (3) send_request(REQ_EXTRACT, $urandom());
    endtask

    // Main sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_ties();
        test_zero_and_wide_limit();
        test_shrunk_limit();
        test_small_limit_traffic();
        test_steady_traffic();
        test_random_limit_traffic();
        test_fill_to_depth();
        wait_for_results(SETTLE + 2);
        if (mismatch_count == 0)
        begin
            $display("PASS max_priority_ticket_queue");
        end
        else
        begin
            $display("FAIL max_priority_ticket_queue");
        end
        $finish;
    end

    // Result side stalls at random unless idling is switched off.
    always @(posedge clk)
    begin
        rsp_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Compare each taken result with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: ticket %0d found %0b",
                       rsp.ticket, rsp.found);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.ticket !== want.ticket)
                begin
                    $error("ticket: expected %0d, actual %0d", want.ticket, rsp.ticket);
                    mismatch_count++;
                end
                if (rsp.found !== want.found)
                begin
                    $error("found: expected %0b, actual %0b", want.found, rsp.found);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if no channel moves anything for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL max_priority_ticket_queue");
            $finish;
        end
    end

endmodule
